// ===== hw/rtl/htw_pkg.sv =====
// shared types and constants of the hashed timer wheel
`default_nettype none

package htw_pkg;

    localparam int HANDLE_W = 6;
    localparam int DELAY_W  = 16;
    localparam int TICK_W   = 32;
    localparam int LINK_W   = 7;
    localparam int SUM_W    = 17;
    localparam int CNT_W    = 5;

    localparam logic [LINK_W-1:0] LINK_NULL = 7'd64;

    typedef enum logic [1:0] {
        OP_ARM     = 2'd0,
        OP_CANCEL  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_TICK    = 2'd3
    } t_op;

    typedef struct packed {
        logic accept;
        logic tick;
        logic mod_start;
        logic node_rd;
        logic unlink;
        logic free;
        logic link_rd;
        logic link_wr;
        logic head_rd;
        logic cur_head;
        logic cur_next;
        logic emit;
        logic push_resp;
        logic push_end;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic bad;
        logic linked;
        logic mod_done;
        logic head_vld;
        logic fires;
        logic nxt_valid;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/htw_req_if.sv =====
// request and result channel interfaces
`default_nettype none

interface htw_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     operation;
    logic [htw_pkg::HANDLE_W-1:0]   handle;
    logic [htw_pkg::DELAY_W-1:0]    delay;

    modport source (output valid, operation, handle, delay, input ready);
    modport sink (input valid, operation, handle, delay, output ready);
endinterface

interface htw_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [htw_pkg::HANDLE_W-1:0]   result_handle;
    logic                           fired;
    logic                           was_allocated;
    logic                           last;

    modport source (output valid, result_handle, fired, was_allocated, last, input ready);
    modport sink (input valid, result_handle, fired, was_allocated, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/htw_ctrl.sv =====
// sequencer of the hashed timer wheel
`default_nettype none

module htw_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire htw_pkg::t_sts i_sts,
    output htw_pkg::t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_MOD, S_URD, S_UWR, S_LRD, S_LWR, S_RESP,
        S_HRD, S_HCHK, S_NRD, S_EVAL, S_EMIT, S_END
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.op == htw_pkg::OP_TICK) begin
                    o_cmd.tick = 1'b1;
                    n_state    = S_HRD;
                end else if (i_sts.bad) begin
                    n_state = S_RESP;
                end else if (i_sts.op == htw_pkg::OP_ARM) begin
                    o_cmd.mod_start = 1'b1;
                    n_state         = S_MOD;
                end else begin
                    o_cmd.free = (i_sts.op == htw_pkg::OP_RELEASE);
                    n_state    = i_sts.linked ? S_URD : S_RESP;
                end
            end
            S_MOD: begin
                if (i_sts.mod_done) begin
                    n_state = i_sts.linked ? S_URD : S_LRD;
                end
            end
            S_URD: begin
                o_cmd.node_rd = 1'b1;
                n_state       = S_UWR;
            end
            S_UWR: begin
                o_cmd.unlink = 1'b1;
                if (i_sts.op == htw_pkg::OP_TICK) begin
                    o_cmd.free = 1'b1;
                    n_state    = S_EMIT;
                end else if (i_sts.op == htw_pkg::OP_ARM) begin
                    n_state = S_LRD;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_LRD: begin
                o_cmd.link_rd = 1'b1;
                n_state       = S_LWR;
            end
            S_LWR: begin
                o_cmd.link_wr = 1'b1;
                n_state       = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.push_resp = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_HRD: begin
                o_cmd.head_rd = 1'b1;
                n_state       = S_HCHK;
            end
            S_HCHK: begin
                if (i_sts.head_vld) begin
                    o_cmd.cur_head = 1'b1;
                    n_state        = S_NRD;
                end else begin
                    n_state = S_END;
                end
            end
            S_NRD: begin
                o_cmd.node_rd = 1'b1;
                n_state       = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.fires) begin
                    n_state = S_UWR;
                end else begin
                    o_cmd.cur_next = 1'b1;
                    n_state        = i_sts.nxt_valid ? S_NRD : S_END;
                end
            end
            S_EMIT: begin
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.nxt_valid ? S_NRD : S_END;
                end
            end
            S_END: begin
                if (i_sts.out_free) begin
                    o_cmd.push_end = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/htw_datapath.sv =====
// handle lists, slot heads, tick counter and result register
`default_nettype none

module htw_datapath #(
    parameter int WHEEL_SLOTS = 60,
    parameter int NUM_HANDLES = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire htw_pkg::t_cmd                 i_cmd,
    output htw_pkg::t_sts                      o_sts,
    input  wire logic [1:0]                    i_operation,
    input  wire logic [htw_pkg::HANDLE_W-1:0]  i_handle,
    input  wire logic [htw_pkg::DELAY_W-1:0]   i_delay,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [htw_pkg::HANDLE_W-1:0]       o_result_handle,
    output logic                               o_fired,
    output logic                               o_was_allocated,
    output logic                               o_last
);

    localparam int HW = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
    localparam int SW = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
    localparam int LW = htw_pkg::LINK_W;
    localparam logic [LW-1:0] NH_L = LW'(NUM_HANDLES);
    localparam logic [SW-1:0] WS_LAST = SW'(WHEEL_SLOTS - 1);
    // reciprocal of the slot count, exact for every sum below 2^SUM_W
    localparam int REC_K  = htw_pkg::SUM_W + 8;
    localparam int REC_W  = REC_K;
    localparam int PROD_W = htw_pkg::SUM_W + REC_W;
    localparam logic [REC_W-1:0] REC_M =
        REC_W'(((64'd1 << REC_K) + 64'(WHEEL_SLOTS) - 64'd1) / 64'(WHEEL_SLOTS));
    localparam logic [htw_pkg::SUM_W-1:0] WS_S = htw_pkg::SUM_W'(WHEEL_SLOTS);

    // control registers
    logic [1:0]                   r_op;
    logic [htw_pkg::HANDLE_W-1:0] r_h;
    logic [htw_pkg::DELAY_W-1:0]  r_d;
    logic                         r_was;
    logic [htw_pkg::TICK_W-1:0]   r_tick;
    logic [SW-1:0]                r_slot;
    logic [LW-1:0]                r_cur;
    logic                         r_mbusy;
    logic [SW-1:0]                r_rem;
    logic [htw_pkg::SUM_W-1:0]    r_sum;
    logic [htw_pkg::SUM_W-1:0]    r_q;
    logic [htw_pkg::CNT_W-1:0]    r_cnt;
    logic                         r_pend_valid;
    logic [htw_pkg::HANDLE_W-1:0] r_pend_h;
    logic                         r_out_valid;
    logic [htw_pkg::HANDLE_W-1:0] r_out_h;
    logic                         r_out_fired;
    logic                         r_out_was;
    logic                         r_out_last;
    logic [NUM_HANDLES-1:0]       r_alloc;
    logic [NUM_HANDLES-1:0]       r_linked;
    logic [WHEEL_SLOTS-1:0]       r_head_vld;

    // memories and their registered read data
    logic [htw_pkg::TICK_W-1:0] dl_mem   [NUM_HANDLES];
    logic [LW-1:0]              nx_mem   [NUM_HANDLES];
    logic [LW-1:0]              pv_mem   [NUM_HANDLES];
    logic [SW-1:0]              sl_mem   [NUM_HANDLES];
    logic [LW-1:0]              head_mem [WHEEL_SLOTS];
    logic [LW-1:0]              tail_mem [WHEEL_SLOTS];

    logic [htw_pkg::TICK_W-1:0] r_rd_dl;
    logic [LW-1:0]              r_rd_nx;
    logic [LW-1:0]              r_rd_pv;
    logic [SW-1:0]              r_rd_sl;
    logic [LW-1:0]              r_rd_head;
    logic [LW-1:0]              r_rd_tail;

    logic [HW-1:0]              cur_idx;
    logic                       p_vld;
    logic                       n_vld;
    logic                       hv;
    logic [htw_pkg::DELAY_W-1:0] d_fix;
    logic [PROD_W-1:0]          mod_prod;
    logic [htw_pkg::SUM_W-1:0]  mod_back;
    logic                       out_free;

    logic nx_we, pv_we, hd_we, tl_we, hd_vld_d;
    logic [HW-1:0] nx_wa, pv_wa;
    logic [LW-1:0] nx_wd, pv_wd, hd_wd, tl_wd;
    logic [SW-1:0] hd_wa, tl_wa;

    assign cur_idx  = r_cur[HW-1:0];
    assign p_vld    = (r_rd_pv < NH_L);
    assign n_vld    = (r_rd_nx < NH_L);
    assign hv       = r_head_vld[r_rem];
    assign d_fix    = (r_d == '0) ? htw_pkg::DELAY_W'(1) : r_d;
    assign mod_prod = PROD_W'(r_sum) * PROD_W'(REC_M);
    assign mod_back = r_q * WS_S;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts            = '0;
        o_sts.op         = htw_pkg::t_op'(r_op);
        o_sts.bad        = ({1'b0, r_h} >= NH_L);
        o_sts.linked     = r_linked[cur_idx];
        o_sts.mod_done   = !r_mbusy;
        o_sts.head_vld   = r_head_vld[r_slot];
        o_sts.fires      = (r_rd_dl <= r_tick);
        o_sts.nxt_valid  = n_vld;
        o_sts.pend_valid = r_pend_valid;
        o_sts.out_free   = out_free;
    end

    // write port selection of the link memories
    always_comb begin
        nx_we = 1'b0; nx_wa = cur_idx; nx_wd = htw_pkg::LINK_NULL;
        pv_we = 1'b0; pv_wa = cur_idx; pv_wd = htw_pkg::LINK_NULL;
        hd_we = 1'b0; hd_wa = r_rem;   hd_wd = r_cur; hd_vld_d = 1'b1;
        tl_we = 1'b0; tl_wa = r_rem;   tl_wd = r_cur;
        if (i_cmd.unlink) begin
            nx_we = p_vld;  nx_wa = r_rd_pv[HW-1:0]; nx_wd = r_rd_nx;
            pv_we = n_vld;  pv_wa = r_rd_nx[HW-1:0]; pv_wd = r_rd_pv;
            hd_we = !p_vld; hd_wa = r_rd_sl; hd_wd = r_rd_nx; hd_vld_d = n_vld;
            tl_we = !n_vld; tl_wa = r_rd_sl; tl_wd = r_rd_pv;
        end else if (i_cmd.link_rd) begin
            nx_we = 1'b1;
        end else if (i_cmd.link_wr) begin
            nx_we = hv;  nx_wa = r_rd_tail[HW-1:0]; nx_wd = r_cur;
            pv_we = 1'b1; pv_wd = hv ? r_rd_tail : htw_pkg::LINK_NULL;
            hd_we = !hv;
            tl_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (nx_we) nx_mem[nx_wa] <= nx_wd;
        if (pv_we) pv_mem[pv_wa] <= pv_wd;
        if (hd_we) head_mem[hd_wa] <= hd_wd;
        if (tl_we) tail_mem[tl_wa] <= tl_wd;
        if (i_cmd.link_wr) begin
            dl_mem[cur_idx] <= r_tick + htw_pkg::TICK_W'(d_fix);
            sl_mem[cur_idx] <= r_rem;
        end
        if (i_cmd.node_rd) begin
            r_rd_dl <= dl_mem[cur_idx];
            r_rd_nx <= nx_mem[cur_idx];
            r_rd_pv <= pv_mem[cur_idx];
            r_rd_sl <= sl_mem[cur_idx];
        end
        if (i_cmd.head_rd) r_rd_head <= head_mem[r_slot];
        if (i_cmd.link_rd) r_rd_tail <= tail_mem[r_rem];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_operation;
            r_h   <= i_handle;
            r_d   <= i_delay;
            r_cur <= {1'b0, i_handle};
            r_was <= ({1'b0, i_handle} < NH_L) && r_alloc[i_handle[HW-1:0]];
        end else if (i_cmd.cur_head) begin
            r_cur <= r_rd_head;
        end else if (i_cmd.cur_next || i_cmd.emit) begin
            r_cur <= r_rd_nx;
        end
        if (i_cmd.mod_start) begin
            r_sum <= htw_pkg::SUM_W'(r_slot) + htw_pkg::SUM_W'(d_fix);
            r_cnt <= htw_pkg::CNT_W'(2);
        end else if (r_mbusy) begin
            // quotient by reciprocal multiply, then remainder by back-multiply
            if (r_cnt == htw_pkg::CNT_W'(2)) begin
                r_q <= mod_prod[PROD_W-1:REC_K];
            end else begin
                r_rem <= SW'(r_sum - mod_back);
            end
            r_cnt <= r_cnt - htw_pkg::CNT_W'(1);
        end
        if (i_cmd.emit) r_pend_h <= r_cur[htw_pkg::HANDLE_W-1:0];
        if (i_cmd.push_resp) begin
            r_out_h <= r_h; r_out_fired <= 1'b0; r_out_was <= r_was; r_out_last <= 1'b1;
        end else if (i_cmd.emit && r_pend_valid) begin
            r_out_h <= r_pend_h; r_out_fired <= 1'b1; r_out_was <= 1'b0; r_out_last <= 1'b0;
        end else if (i_cmd.push_end) begin
            r_out_h     <= r_pend_valid ? r_pend_h : '0;
            r_out_fired <= r_pend_valid;
            r_out_was   <= 1'b0;
            r_out_last  <= 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_slot       <= '0;
            r_mbusy      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_alloc      <= '0;
            r_linked     <= '0;
            r_head_vld   <= '0;
        end else begin
            if (i_cmd.tick) begin
                r_tick <= r_tick + htw_pkg::TICK_W'(1);
                r_slot <= (r_slot == WS_LAST) ? '0 : r_slot + SW'(1);
            end
            if (i_cmd.mod_start) begin
                r_mbusy <= 1'b1;
            end else if (r_mbusy && r_cnt == htw_pkg::CNT_W'(1)) begin
                r_mbusy <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.push_end) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.push_resp || i_cmd.push_end || (i_cmd.emit && r_pend_valid)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (hd_we) r_head_vld[hd_wa] <= hd_vld_d;
            if (i_cmd.unlink) r_linked[cur_idx] <= 1'b0;
            if (i_cmd.free) r_alloc[cur_idx] <= 1'b0;
            if (i_cmd.link_wr) begin
                r_linked[cur_idx] <= 1'b1;
                r_alloc[cur_idx]  <= 1'b1;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_handle = r_out_h;
    assign o_fired         = r_out_fired;
    assign o_was_allocated = r_out_was;
    assign o_last          = r_out_last;

endmodule

`default_nettype wire

// ===== hw/rtl/hashed_timer_wheel.sv =====
// top level of the hashed timer wheel
//
// usage
// - i_req carries one request: operation (arm, cancel, release, tick),
//   handle and delay; it is taken when valid and ready are both high
// - o_rsp carries results: one per arm, cancel or release (was_allocated
//   tells whether the handle was live), and for a tick one per expired
//   handle in insertion order, or a single empty result; last marks the
//   final result of a request
// - one request at a time; ready returns once the request's final result
//   sits in the output register, so the next request overlaps its delivery
// - cancel and release unlink the handle's node if it is linked; arm runs the
//   two-step reciprocal slot remainder unit, then the list updates; a tick reads
//   the slot head and walks the slot node by node, each list node being a
//   registered memory read
// - reset clears the counter, the allocation and link flags and the slot
//   valid bits at once; no clearing pass is needed
// - a stalled receiver holds the result register and pauses the slot walk
// - a delay of zero counts as one tick
`default_nettype none

module hashed_timer_wheel #(
    parameter int WHEEL_SLOTS = 60,
    parameter int NUM_HANDLES = 64
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    htw_req_if.sink    i_req,
    htw_rsp_if.source  o_rsp
);

    htw_pkg::t_cmd cmd;
    htw_pkg::t_sts sts;

    // sequencer: decodes a request and steps the list operations
    htw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: handle lists, slot heads and tails, counter, result register
    htw_datapath #(
        .WHEEL_SLOTS (WHEEL_SLOTS),
        .NUM_HANDLES (NUM_HANDLES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_operation     (i_req.operation),
        .i_handle        (i_req.handle),
        .i_delay         (i_req.delay),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_result_handle (o_rsp.result_handle),
        .o_fired         (o_rsp.fired),
        .o_was_allocated (o_rsp.was_allocated),
        .o_last          (o_rsp.last)
    );

    // a result that is not a firing always closes its request
    a_plain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.fired |-> o_rsp.last)
        else $error("non-fired result without last");

    // firing results never report allocation
    a_fired_was: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.fired |-> !o_rsp.was_allocated)
        else $error("fired result with was_allocated");

    // the block is busy right after taking a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request taken while busy");

    // only one list write step per cycle
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.unlink, cmd.link_rd, cmd.link_wr}))
        else $error("conflicting list commands");

endmodule

`default_nettype wire
